// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked property, masked while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/tgrr_pkg.sv =====
package tgrr_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int MAX_SLOTS = 64;
  localparam int MAX_IDX_W = 6;

  localparam int IDX_W  = 13;
  localparam int SLOT_W = 3;
  localparam int ACT_W  = 2;
  localparam int KIND_W = 2;

  localparam logic [IDX_W-1:0] GROUP_A_BASE_RST = 13'd0;
  localparam logic [IDX_W-1:0] GROUP_B_BASE_RST = 13'd8;
  localparam logic [IDX_W-1:0] IDLE_INDEX_RST   = 13'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_SET  = 2'd1,
    ACT_CLR  = 2'd2
  } action_t;

  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_A    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_B    = 2'd2;

  localparam logic [1:0] REG_GROUP_A_BASE = 2'd0;
  localparam logic [1:0] REG_GROUP_B_BASE = 2'd1;
  localparam logic [1:0] REG_IDLE_INDEX   = 2'd2;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [MAX_IDX_W-1:0] lowest_set(input logic [MAX_SLOTS-1:0] v);
    logic [MAX_IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = MAX_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/tgrr_rr_next.sv =====
module tgrr_rr_next #(
  parameter int SLOTS = tgrr_pkg::SLOTS_DEF,
  parameter int PTR_W = $clog2(SLOTS)
) (
  input  logic [SLOTS-1:0] mask,
  input  logic [PTR_W-1:0] ptr,
  output logic [PTR_W-1:0] ptr_nxt
);

  logic [SLOTS-1:0]               above;
  logic [tgrr_pkg::MAX_IDX_W-1:0] pick;

  // Prefer the first active slot past the pointer, else wrap to the lowest.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      above[i] = mask[i] && (PTR_W'(i) > ptr);
    end
    if (|above) begin
      pick = tgrr_pkg::lowest_set(tgrr_pkg::MAX_SLOTS'(above));
    end else begin
      pick = tgrr_pkg::lowest_set(tgrr_pkg::MAX_SLOTS'(mask));
    end
  end

  assign ptr_nxt = pick[PTR_W-1:0];

endmodule

// ===== rtl/two_group_round_robin_task_picker.sv =====
// Path: an accepted transaction goes through the input and then the result register.
// Throughput: one transaction per clock unless out_tready stalls; an input register and
//   a result register flank a combinational pick (rotated priority encode plus base add).
// Backpressure on out_tready stalls the pick stage; in_tready drops only when both
//   registers hold a transaction and out_tready is low.
// Reset (rst_n low, synchronous): masks and pointers clear, group A is served first,
//   bases return to 0 and 8, idle index to 16.
`include "assert_macros.svh"

module two_group_round_robin_task_picker #(
  parameter int SLOTS = tgrr_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] group, [3:1] slot, [7:4] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] pick_slot, [15:3] pick_index, [16] has_free,
                                  // [19:17] free_slot, [23:20] zero
  output logic [1:0]  out_tuser,  // [1:0] pick_kind
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int PTR_W = $clog2(SLOTS);
  localparam int IDX_W = tgrr_pkg::IDX_W;
  localparam int SLT_W = tgrr_pkg::SLOT_W;

  // Configuration registers
  logic [IDX_W-1:0] base_a_r, base_b_r, idle_idx_r;

  // Input register
  logic                              s1_valid_r;
  logic [tgrr_pkg::ACT_W-1:0]        s1_action_r;
  logic                              s1_group_r;
  logic [SLT_W-1:0]                  s1_slot_r;

  // Scheduler state
  logic [SLOTS-1:0] active_a_r, active_b_r, active_a_nxt, active_b_nxt;
  logic [PTR_W-1:0] ptr_a_r, ptr_b_r, ptr_a_nxt, ptr_b_nxt;
  logic             serve_b_r, serve_b_nxt;

  // Result register
  logic                       out_valid_r;
  logic [tgrr_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [SLT_W-1:0]           pslot_r, pslot_nxt;
  logic [IDX_W-1:0]           pidx_r, pidx_nxt;
  logic                       has_free_r, has_free_nxt;
  logic [SLT_W-1:0]           free_slot_r, free_slot_nxt;

  logic                              fire;
  logic [PTR_W-1:0]                  adv_a, adv_b;
  logic                              slot_ok;
  logic [SLOTS-1:0]                  slot_bit, named, free_bits;
  logic [tgrr_pkg::MAX_IDX_W-1:0]    ptr_wide, free_wide;

  // Advance the pick stage whenever the result register can take a new value.
  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;
  assign cfg_ready = 1'b1;

  tgrr_rr_next #(.SLOTS(SLOTS), .PTR_W(PTR_W)) u_next_a (
    .mask    (active_a_r),
    .ptr     (ptr_a_r),
    .ptr_nxt (adv_a)
  );

  tgrr_rr_next #(.SLOTS(SLOTS), .PTR_W(PTR_W)) u_next_b (
    .mask    (active_b_r),
    .ptr     (ptr_b_r),
    .ptr_nxt (adv_b)
  );

  always_comb begin
    active_a_nxt = active_a_r;
    active_b_nxt = active_b_r;
    ptr_a_nxt    = ptr_a_r;
    ptr_b_nxt    = ptr_b_r;
    serve_b_nxt  = serve_b_r;
    kind_nxt     = tgrr_pkg::KIND_IDLE;
    ptr_wide     = '0;
    pidx_nxt     = '0;

    // Slots beyond the mask width are dropped on activate and deactivate.
    slot_ok  = {4'b0, s1_slot_r} < 7'(SLOTS);
    slot_bit = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_bit[i] = (SLT_W'(i) == s1_slot_r) && ((i >> SLT_W) == 0);
    end

    case (s1_action_r)
      tgrr_pkg::ACT_TICK: begin
        if ((|active_a_r) && (!serve_b_r || !(|active_b_r))) begin
          ptr_a_nxt   = adv_a;
          serve_b_nxt = 1'b1;
          kind_nxt    = tgrr_pkg::KIND_A;
          ptr_wide    = tgrr_pkg::MAX_IDX_W'(adv_a);
          pidx_nxt    = base_a_r + IDX_W'(adv_a);
        end else if (|active_b_r) begin
          ptr_b_nxt   = adv_b;
          serve_b_nxt = 1'b0;
          kind_nxt    = tgrr_pkg::KIND_B;
          ptr_wide    = tgrr_pkg::MAX_IDX_W'(adv_b);
          pidx_nxt    = base_b_r + IDX_W'(adv_b);
        end else begin
          pidx_nxt    = idle_idx_r;
        end
      end
      tgrr_pkg::ACT_SET: begin
        if (slot_ok) begin
          if (s1_group_r) active_b_nxt = active_b_r | slot_bit;
          else            active_a_nxt = active_a_r | slot_bit;
        end
      end
      tgrr_pkg::ACT_CLR: begin
        if (slot_ok) begin
          if (s1_group_r) active_b_nxt = active_b_r & ~slot_bit;
          else            active_a_nxt = active_a_r & ~slot_bit;
        end
      end
      default: begin
      end
    endcase

    pslot_nxt = ptr_wide[SLT_W-1:0];

    // Free-slot report uses the masks after this transaction's update.
    named         = s1_group_r ? active_b_nxt : active_a_nxt;
    free_bits     = ~named;
    has_free_nxt  = |free_bits;
    free_wide     = tgrr_pkg::lowest_set(tgrr_pkg::MAX_SLOTS'(free_bits));
    free_slot_nxt = free_wide[SLT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_a_r    <= tgrr_pkg::GROUP_A_BASE_RST;
      base_b_r    <= tgrr_pkg::GROUP_B_BASE_RST;
      idle_idx_r  <= tgrr_pkg::IDLE_INDEX_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      active_a_r  <= '0;
      active_b_r  <= '0;
      ptr_a_r     <= '0;
      ptr_b_r     <= '0;
      serve_b_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tgrr_pkg::REG_GROUP_A_BASE: base_a_r   <= cfg_data;
          tgrr_pkg::REG_GROUP_B_BASE: base_b_r   <= cfg_data;
          tgrr_pkg::REG_IDLE_INDEX:   idle_idx_r <= cfg_data;
          default: begin
          end
        endcase
      end
      // Hold the input register while the pick stage is stalled.
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        active_a_r  <= active_a_nxt;
        active_b_r  <= active_b_nxt;
        ptr_a_r     <= ptr_a_nxt;
        ptr_b_r     <= ptr_b_nxt;
        serve_b_r   <= serve_b_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_action_r <= in_tuser;
      s1_group_r  <= in_tdata[0];
      s1_slot_r   <= in_tdata[3:1];
    end
    if (fire) begin
      kind_r      <= kind_nxt;
      pslot_r     <= pslot_nxt;
      pidx_r      <= pidx_nxt;
      has_free_r  <= has_free_nxt;
      free_slot_r <= free_slot_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {4'b0, free_slot_r, has_free_r, pidx_r, pslot_r};

  // A shown pick always names a slot that is still active.
  `ASSERT_RST(a_pick_a_active, clk, rst_n,
    (out_valid_r && kind_r == tgrr_pkg::KIND_A) |-> active_a_r[ptr_a_r], "pick A not active")
  `ASSERT_RST(a_pick_b_active, clk, rst_n,
    (out_valid_r && kind_r == tgrr_pkg::KIND_B) |-> active_b_r[ptr_b_r], "pick B not active")
  // With both groups busy, each tick hands service to the other group.
  `ASSERT_RST(a_alternate, clk, rst_n,
    (fire && s1_action_r == tgrr_pkg::ACT_TICK && (|active_a_r) && (|active_b_r))
      |=> (serve_b_r != $past(serve_b_r)), "groups did not alternate")
  // The input stream stalls only while the input register holds a transaction.
  `ASSERT_ALWAYS(a_no_drop, clk,
    (rst_n && !in_tready) |-> s1_valid_r, "input stalled while empty")

endmodule
